// ----- rtl/psc_pkg.sv -----
// Shared types, constants and helpers for the pedal sensor calibrate/normalise block.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package psc_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int POS_W             = 12;
	localparam int CFG_W             = 16;
	localparam int CFG_IDX_W         = 2;
	localparam int HISTORY_DEPTH_DEF = 16;

	localparam logic [POS_W-1:0] FULL_SCALE = 12'd2095;

	localparam logic [CFG_W-1:0] MIN_RANGE_RST  = 16'd100;
	localparam logic [CFG_W-1:0] SETTLE_TOL_RST = 16'd10;
	localparam logic [CFG_W-1:0] IDLE_TOL_RST   = 16'd15;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_RANGE  = 2'd0,
		CFG_SETTLE_TOL = 2'd1,
		CFG_IDLE_TOL   = 2'd2
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_START,
		S_DIV,
		S_OUT
	} state_t;

	// Absolute difference of two samples.
	function automatic logic [SAMPLE_W-1:0] dist16(input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ----- rtl/psc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module psc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/psc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in QW bits. No dependencies.
`timescale 1ns / 1ps

module psc_div #(
	parameter int QW = 12,
	parameter int DW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QW+DW-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic [QW-1:0]    quotient,
	output logic             busy
);

	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          fits;

	// Trial subtraction of one step.
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		fits  = (trial >= {1'b0, div_q});
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CW'(1));
			cnt_q  <= cnt_q - CW'(1);
		end
	end

	// Remainder and quotient shift register; dividend bits shift out as quotient bits enter.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[QW+DW-1:QW];
			quo_q <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

// ----- rtl/pedal_sensor_calibrate_normalise_top.sv -----
// Pedal sensor calibration and normalisation, top level.
// Depends on psc_pkg, psc_ram and psc_div.
`timescale 1ns / 1ps
//
//  Channel   Direction  Signals                           Content
//  s_*       in         s_tvalid s_tready s_tdata[15:0]   raw pedal sample
//  m_*       out        m_tvalid m_tready m_tdata m_tuser position, flags
//  cfg_*     in         cfg_we cfg_index cfg_data         register writes
//
//  An accepted input transaction passes through the sequencer states in order: the ring
//  read together with the acceptance, the ring and state update, operand setup, the
//  division state (the 12 quotient bits of the serial position divider, left once the
//  divider has finished), and the result state. The ring average is a reciprocal
//  multiplication. A new sample is taken only once the sequencer is back in idle.
//  The history ring lives in a RAM whose entries carry valid bits that reset clears at
//  once, so there is no clearing pass. A result waits in the output register; a new
//  sample is accepted meanwhile and the sequencer holds in the result state until the
//  previous result has been taken.

module pedal_sensor_calibrate_normalise_top #(
	parameter int HISTORY_DEPTH = psc_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,  // [15:0] sample
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,  // [11:0] position, [15:12] zero
	output logic [1:0]                      m_tuser,  // [0] is_calibrated, [1] is_idle
	input  logic                            cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psc_pkg::CFG_W-1:0]       cfg_data
);

	import psc_pkg::*;

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = SAMPLE_W + AW;
	localparam int PDW   = SAMPLE_W;

	// Ring average as floor(sum * AVG_RECIP / 2^AVG_K), exact for every sum below 2^SUM_W.
	localparam int AVG_K  = SUM_W + AW;
	localparam int AVG_MW = SUM_W + 1;
	localparam int AVG_PW = SUM_W + AVG_MW;
	localparam logic [63:0] AVG_RECIP_FULL =
		((64'd1 << AVG_K) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
	localparam logic [AVG_MW-1:0] AVG_RECIP = AVG_RECIP_FULL[AVG_MW-1:0];

	state_t state_q, state_nx;

	logic [CFG_W-1:0]    min_range_q, settle_tol_q, idle_tol_q;
	logic [SAMPLE_W-1:0] sample_q, start_q, low_q, high_q;
	logic                start_valid_q, cal_done_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AW-1:0]       ptr_q;
	logic [HISTORY_DEPTH-1:0] hvalid_q;

	logic [POS_W-1:0]    out_pos_q;
	logic                out_cal_q, out_idle_q, m_tvalid_q;

	logic                in_xfer, ram_re, ram_we, div_start, out_load, div_done;
	logic [SAMPLE_W-1:0] ram_rdata, old_entry;
	logic [SAMPLE_W-1:0] start_nx, low_nx, high_nx;
	logic [SUM_W-1:0]    sum_nx;
	logic [AW-1:0]       ptr_nx;

	logic [SAMPLE_W-1:0] clamped, offset;
	logic [POS_W+PDW-1:0] pos_dividend;
	logic [POS_W-1:0]    pos_quo, pos_clip, pos_val;
	logic                pos_busy;
	logic [AVG_PW-1:0]   avg_prod;
	logic [SAMPLE_W-1:0] avg_q;
	logic                far_from_start, settled, range_empty, inverted;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q  <= MIN_RANGE_RST;
			settle_tol_q <= SETTLE_TOL_RST;
			idle_tol_q   <= IDLE_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_RANGE:  min_range_q  <= cfg_data;
				CFG_SETTLE_TOL: settle_tol_q <= cfg_data;
				CFG_IDLE_TOL:   idle_tol_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// History ring. One item is in flight at a time, so a read never meets a pending write.
	psc_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata(sample_q),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign in_xfer  = s_tvalid && s_tready;
	assign div_done = !pos_busy;

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  if (in_xfer) state_nx = S_READ;
			S_READ:  state_nx = S_START;
			S_START: state_nx = S_DIV;
			S_DIV:   if (div_done) state_nx = S_OUT;
			S_OUT:   if (!m_tvalid_q || m_tready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				ram_re   = s_tvalid;
			end
			S_READ:  ram_we    = !cal_done_q;
			S_START: div_start = 1'b1;
			S_OUT:   out_load  = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Calibration update from the entry leaving the ring.
	always_comb begin
		old_entry = hvalid_q[ptr_q] ? ram_rdata : '0;
		start_nx  = start_valid_q ? start_q : sample_q;
		low_nx    = (sample_q < low_q) ? sample_q : low_q;
		high_nx   = (sample_q > high_q) ? sample_q : high_q;
		sum_nx    = sum_q - SUM_W'(old_entry) + SUM_W'(sample_q);
		ptr_nx    = (ptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= s_tdata;
		end
	end

	// Calibration state; frozen once calibration has completed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q       <= '1;
			start_valid_q <= 1'b0;
			low_q         <= '1;
			high_q        <= '0;
			sum_q         <= '0;
			ptr_q         <= '0;
			hvalid_q      <= '0;
			cal_done_q    <= 1'b0;
		end else begin
			if (ram_we) begin
				start_q         <= start_nx;
				start_valid_q   <= 1'b1;
				low_q           <= low_nx;
				high_q          <= high_nx;
				sum_q           <= sum_nx;
				ptr_q           <= ptr_nx;
				hvalid_q[ptr_q] <= 1'b1;
			end
			if (state_q == S_DIV && div_done && !cal_done_q && far_from_start && settled) begin
				cal_done_q <= 1'b1;
			end
		end
	end

	// Divider operands from the updated state.
	always_comb begin
		clamped      = (sample_q < low_q) ? low_q : ((sample_q > high_q) ? high_q : sample_q);
		offset       = clamped - low_q;
		pos_dividend = (POS_W + PDW)'(offset) * (POS_W + PDW)'(FULL_SCALE);
	end

	psc_div #(
		.QW(POS_W),
		.DW(PDW)
	) u_pos_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(pos_dividend),
		.divisor (high_q - low_q),
		.quotient(pos_quo),
		.busy    (pos_busy)
	);

	// Ring average from the updated sum, registered while the divider starts.
	assign avg_prod = AVG_PW'(sum_q) * AVG_PW'(AVG_RECIP);

	always_ff @(posedge clk) begin
		if (div_start) begin
			avg_q <= avg_prod[AVG_K +: SAMPLE_W];
		end
	end

	// Completion test and final position.
	always_comb begin
		far_from_start = (dist16(sample_q, start_q) >= min_range_q);
		settled        = (dist16(sample_q, avg_q) <= settle_tol_q);
		range_empty    = (high_q <= low_q);
		inverted       = (dist16(start_q, low_q) > min_range_q);
		pos_clip       = (pos_quo > FULL_SCALE) ? FULL_SCALE : pos_quo;
		if (range_empty) begin
			pos_val = '0;
		end else if (inverted) begin
			pos_val = FULL_SCALE - pos_clip;
		end else begin
			pos_val = pos_clip;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q  <= pos_val;
			out_cal_q  <= cal_done_q;
			out_idle_q <= (dist16(sample_q, start_q) < idle_tol_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_pos_q};
	assign m_tuser  = {out_idle_q, out_cal_q};

`ifndef ASSERT_OFF
	// The divider only runs between operand setup and the result.
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_READ) |-> !pos_busy)
		else $error("divider busy outside of the division phase");

	// Calibration, once complete, stays complete.
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(cal_done_q))
		else $error("calibrated flag dropped");

	// Once a start has been captured, the tracked range is ordered.
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		start_valid_q |-> (low_q <= high_q))
		else $error("minimum above maximum after start capture");

	// A new result appears only from the result state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_OUT))
		else $error("result valid raised outside of the result state");

	// The position never exceeds full scale.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:0] <= FULL_SCALE))
		else $error("position beyond full scale");
`endif

endmodule
